FILE: rtl/ilid_pkg.sv
// Shared types and constants for the indexed list block.
// No dependencies; imported by indexed_list_insert_delete.
package ilid_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OP_W     = 3;
  localparam int POS_W    = 16;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;

  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_HEAD   = 3'd1;
  localparam logic [OP_W-1:0] OP_TAIL   = 3'd2;
  localparam logic [OP_W-1:0] OP_AT     = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MOVE_RD,
    S_MOVE_WR,
    S_PUT,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_READ,
    JOB_INSERT,
    JOB_DELETE
  } job_t;

endpackage

FILE: rtl/indexed_list_insert_delete.sv
// Indexed list: ordered store of up to CAPACITY signed 32-bit values.
// Depends on ilid_pkg (types, op and status codes, sizes).
// Holds the entry memory and the move sequencer.

// Usage: pulse start with operation, position and item_value while busy is
// low. The request is taken on that edge; busy stays high until the result
// beat, which appears on read_value/status/length_after for exactly one cycle
// with done high. The receiver cannot stall, so every beat must be taken as
// it comes. The next request may be issued in the same cycle the done beat is
// shown. A read passes through S_FETCH, a rejected request goes straight to
// S_FINISH, and an insert or delete first shifts the tail of the list, if
// any. The sequencer uses the entry memory one port at a time: each shifted
// entry takes a registered read in S_MOVE_RD, then a write one slot over in
// S_MOVE_WR, driven by one cursor counter and its compare. No memory clearing
// is needed after reset: entries at or beyond the count are never read.
module indexed_list_insert_delete (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [ilid_pkg::OP_W-1:0]             operation,
  input  logic signed [ilid_pkg::POS_W-1:0]     position,
  input  logic signed [ilid_pkg::VAL_W-1:0]     item_value,
  output logic                                  done,
  output logic signed [ilid_pkg::VAL_W-1:0]     read_value,
  output logic [ilid_pkg::STAT_W-1:0]           status,
  output logic [ilid_pkg::CNT_W-1:0]            length_after
);
  import ilid_pkg::*;

  // Control state
  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  job_t               job, job_next;
  logic [STAT_W-1:0]  stat, stat_next;
  logic [IDX_W-1:0]   slot, slot_next;
  logic [CNT_W-1:0]   cursor, cursor_next;
  logic [VAL_W-1:0]   value, value_next;

  // Result beat registers
  logic               done_next;
  logic [VAL_W-1:0]   read_value_next;
  logic [STAT_W-1:0]  status_next;
  logic [CNT_W-1:0]   length_after_next;

  // Entry memory
  logic [VAL_W-1:0]   mem [CAPACITY];
  logic [VAL_W-1:0]   rd_data;
  logic               mem_rd_en;
  logic [IDX_W-1:0]   mem_rd_addr;
  logic               mem_wr_en;
  logic [IDX_W-1:0]   mem_wr_addr;
  logic [VAL_W-1:0]   mem_wr_data;

  // Request decode
  logic               accept;
  logic [POS_W-1:0]   pos_abs;
  logic [POS_W-1:0]   count_wide;
  logic               in_list;
  logic               at_ok;
  logic               full;
  job_t               dec_job;
  logic [STAT_W-1:0]  dec_stat;
  logic [IDX_W-1:0]   dec_slot;

  // Shared cursor unit
  logic [CNT_W-1:0]   cursor_step;
  logic               move_last;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    pos_abs    = {1'b0, position[POS_W-2:0]};
    count_wide = POS_W'(count);
    in_list    = !position[POS_W-1] && (pos_abs < count_wide);
    at_ok      = position[POS_W-1] || (pos_abs <= count_wide);
    full       = (count == CNT_W'(CAPACITY));
    dec_job    = JOB_NONE;
    dec_stat   = ST_RANGE;
    dec_slot   = '0;
    case (operation)
      OP_READ: begin
        if (in_list) begin
          dec_job  = JOB_READ;
          dec_stat = ST_DONE;
          dec_slot = position[IDX_W-1:0];
        end
      end
      OP_HEAD, OP_TAIL, OP_AT: begin
        if (operation == OP_AT && !at_ok) begin
          dec_stat = ST_RANGE;
        end else if (full) begin
          dec_stat = ST_FULL;
        end else begin
          dec_job  = JOB_INSERT;
          dec_stat = ST_DONE;
          if (operation == OP_TAIL) begin
            dec_slot = count[IDX_W-1:0];
          end else if (operation == OP_AT && !position[POS_W-1]) begin
            dec_slot = position[IDX_W-1:0];
          end
        end
      end
      OP_DELETE: begin
        if (in_list) begin
          dec_job  = JOB_DELETE;
          dec_stat = ST_DONE;
          dec_slot = position[IDX_W-1:0];
        end
      end
      default: begin
        dec_stat = ST_RANGE;
      end
    endcase
  end

  // Cursor walks down for an insert (source index), up for a delete.
  always_comb begin
    cursor_step = (job == JOB_INSERT) ? cursor - 1'b1 : cursor + 1'b1;
    move_last   = (job == JOB_INSERT) ? (cursor == CNT_W'(slot))
                                      : (cursor_step == count);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (dec_job)
            JOB_READ:   state_next = S_FETCH;
            JOB_INSERT: state_next = (count == CNT_W'(dec_slot)) ? S_PUT : S_MOVE_RD;
            JOB_DELETE: state_next = (CNT_W'(dec_slot) + 1'b1 == count) ? S_FINISH
                                                                        : S_MOVE_RD;
            default:    state_next = S_FINISH;
          endcase
        end
      end
      S_FETCH:   state_next = S_FINISH;
      S_MOVE_RD: state_next = S_MOVE_WR;
      S_MOVE_WR: begin
        if (move_last) begin
          state_next = (job == JOB_INSERT) ? S_PUT : S_FINISH;
        end else begin
          state_next = S_MOVE_RD;
        end
      end
      S_PUT:     state_next = S_FINISH;
      S_FINISH:  state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Datapath, memory control and result beat
  always_comb begin
    job_next          = job;
    stat_next         = stat;
    slot_next         = slot;
    cursor_next       = cursor;
    value_next        = value;
    count_next        = count;
    mem_rd_en         = 1'b0;
    mem_rd_addr       = slot;
    mem_wr_en         = 1'b0;
    mem_wr_addr       = slot;
    mem_wr_data       = value;
    done_next         = 1'b0;
    read_value_next   = '0;
    status_next       = stat;
    length_after_next = count;
    case (state)
      S_IDLE: begin
        if (accept) begin
          job_next   = dec_job;
          stat_next  = dec_stat;
          slot_next  = dec_slot;
          value_next = item_value;
          // first source entry of the move
          if (dec_job == JOB_INSERT) begin
            cursor_next = count - 1'b1;
          end else begin
            cursor_next = CNT_W'(dec_slot) + 1'b1;
          end
        end
      end
      S_FETCH: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = slot;
      end
      S_MOVE_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = cursor[IDX_W-1:0];
      end
      S_MOVE_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = rd_data;
        mem_wr_addr = (job == JOB_INSERT) ? cursor[IDX_W-1:0] + 1'b1
                                          : cursor[IDX_W-1:0] - 1'b1;
        if (!move_last) begin
          cursor_next = cursor_step;
        end
      end
      S_PUT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = slot;
        mem_wr_data = value;
      end
      S_FINISH: begin
        if (job == JOB_INSERT) begin
          count_next = count + 1'b1;
        end else if (job == JOB_DELETE) begin
          count_next = count - 1'b1;
        end
        done_next         = 1'b1;
        read_value_next   = (job == JOB_READ) ? rd_data : '0;
        status_next       = stat;
        length_after_next = count_next;
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      rd_data <= mem[mem_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      job   <= JOB_NONE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      job   <= job_next;
      done  <= done_next;
    end
    stat         <= stat_next;
    slot         <= slot_next;
    cursor       <= cursor_next;
    value        <= value_next;
    read_value   <= read_value_next;
    status       <= status_next;
    length_after <= length_after_next;
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for indexed_list_insert_delete: a list scoreboard class plus driving tasks.
// Depends on ilid_pkg for sizes, op and status codes; needs only the RTL.

import ilid_pkg::*;

// Scoreboard: keeps its own copy of the list, predicts one result per
// accepted request and checks each result beat against the oldest prediction.
class list_scoreboard;
  typedef struct {
    logic signed [VAL_W-1:0] rv;
    logic [STAT_W-1:0]       st;
    logic [CNT_W-1:0]        len;
  } outcome_t;

  logic signed [VAL_W-1:0] slots [CAPACITY];
  int                      count;
  outcome_t                outcome_q [$];
  int                      errors;

  function new();
    count  = 0;
    errors = 0;
  endfunction

  function int pending();
    return outcome_q.size();
  endfunction

  // Open a hole at slot and drop the value in; refused when full.
  function logic [STAT_W-1:0] insert_at(int slot, logic signed [VAL_W-1:0] val);
    if (count >= CAPACITY) return ST_FULL;
    for (int i = count; i > slot; i--) slots[i] = slots[i-1];
    slots[slot] = val;
    count++;
    return ST_DONE;
  endfunction

  function void note_request(logic [OP_W-1:0] op, logic signed [POS_W-1:0] pos,
                             logic signed [VAL_W-1:0] val);
    outcome_t o;
    int       p;
    bit       in_list;
    p         = pos;
    in_list   = (p >= 0) && (p < count);
    o.rv      = '0;
    o.st      = ST_RANGE;
    case (op)
      OP_READ: begin
        if (in_list) begin
          o.rv = slots[p];
          o.st = ST_DONE;
        end
      end
      OP_HEAD: o.st = insert_at(0, val);
      OP_TAIL: o.st = insert_at(count, val);
      OP_AT: begin
        // range check comes before the full check
        if (p < 0) o.st = insert_at(0, val);
        else if (p <= count) o.st = insert_at(p, val);
      end
      OP_DELETE: begin
        if (in_list) begin
          for (int i = p; i < count - 1; i++) slots[i] = slots[i+1];
          count--;
          o.st = ST_DONE;
        end
      end
      default: o.st = ST_RANGE;
    endcase
    o.len = CNT_W'(count);
    outcome_q.push_back(o);
  endfunction

  function void check_result(logic signed [VAL_W-1:0] rv, logic [STAT_W-1:0] st,
                             logic [CNT_W-1:0] len);
    outcome_t o;
    if (outcome_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: unexpected result beat value=%0d status=%0d length=%0d",
                 rv, st, len);
      return;
    end
    o = outcome_q.pop_front();
    if (rv !== o.rv || st !== o.st || len !== o.len) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: result mismatch exp value=%0d status=%0d length=%0d, got %0d %0d %0d",
                 o.rv, o.st, o.len, rv, st, len);
    end
  endfunction
endclass

module tb_top;
  // Op mix for a stretch of random requests: grow pushes the list to full,
  // shrink drains it to empty, mix stays in between.
  typedef enum int {MOOD_GROW, MOOD_SHRINK, MOOD_MIX} mood_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [OP_W-1:0]          operation = OP_READ;
  logic signed [POS_W-1:0]  position = '0;
  logic signed [VAL_W-1:0]  item_value = '0;
  logic                     done;
  logic signed [VAL_W-1:0]  read_value;
  logic [STAT_W-1:0]        status;
  logic [CNT_W-1:0]         length_after;

  list_scoreboard sb = new();

  indexed_list_insert_delete u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .position     (position),
    .item_value   (item_value),
    .done         (done),
    .read_value   (read_value),
    .status       (status),
    .length_after (length_after)
  );

  // 12 ns clock, 6 high / 6 low
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result beats last one cycle and cannot be held off: take every one.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(read_value, status, length_after);
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #30ms;
    $display("Regression FAIL");
    $finish;
  end

  // Called at a falling edge. Holds the beat until the edge where busy is low,
  // notes it in the scoreboard, returns at the next falling edge with start
  // still high so back-to-back beats need no low pulse.
  task send_item(logic [OP_W-1:0] op, logic signed [POS_W-1:0] pos,
                 logic signed [VAL_W-1:0] val);
    start      <= 1'b1;
    operation  <= op;
    position   <= pos;
    item_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(op, pos, val);
    @(negedge clk);
  endtask

  // Random sender gaps, pct in percent per cycle.
  task idle_gaps(int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  task send_gapped(int pct, logic [OP_W-1:0] op, logic signed [POS_W-1:0] pos,
                   logic signed [VAL_W-1:0] val);
    idle_gaps(pct);
    send_item(op, pos, val);
  endtask

  // Hold off until every predicted beat has arrived; always waits on a falling
  // edge first so start gets a single assignment per edge.
  task drain();
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Build one random request around the current predicted length.
  task pick_request(mood_t mood, output logic [OP_W-1:0] op,
                    output logic signed [POS_W-1:0] pos,
                    output logic signed [VAL_W-1:0] val);
    int r;
    int cnt;
    int p;
    int t_read, t_head, t_tail, t_at, t_del;
    cnt = sb.count;
    r   = $urandom_range(99);
    case (mood)
      MOOD_GROW: begin
        t_read = 10; t_head = 30; t_tail = 50; t_at = 85; t_del = 97;
      end
      MOOD_SHRINK: begin
        t_read = 15; t_head = 23; t_tail = 31; t_at = 45; t_del = 97;
      end
      default: begin
        t_read = 25; t_head = 40; t_tail = 55; t_at = 75; t_del = 97;
      end
    endcase
    if (r < t_read) op = OP_READ;
    else if (r < t_head) op = OP_HEAD;
    else if (r < t_tail) op = OP_TAIL;
    else if (r < t_at) op = OP_AT;
    else if (r < t_del) op = OP_DELETE;
    else op = OP_DELETE + OP_W'($urandom_range(1, 3));  // undefined codes

    // mostly in-list positions, with the edges and raw junk mixed in
    case ($urandom_range(9))
      6: p = cnt;
      7: p = -int'($urandom_range(1, 3));
      8: p = int'($urandom);
      9: begin
        case ($urandom_range(3))
          0: p = -32768;
          1: p = 32767;
          2: p = cnt + 1;
          default: p = cnt - 1;
        endcase
      end
      default: p = $urandom_range(0, cnt);
    endcase
    pos = POS_W'(p);

    if ($urandom_range(15) == 0) begin
      case ($urandom_range(3))
        0: val = 32'sh8000_0000;
        1: val = 32'sh7fff_ffff;
        2: val = '0;
        default: val = -1;
      endcase
    end else begin
      val = $urandom;
    end
  endtask

  task run_random(int n_items, int pct);
    mood_t                   mood;
    logic [OP_W-1:0]         op;
    logic signed [POS_W-1:0] pos;
    logic signed [VAL_W-1:0] val;
    mood = MOOD_GROW;
    for (int i = 0; i < n_items; i++) begin
      // first two stretches always grow so the full list is reached early
      if (i % 64 == 0 && i >= 128) mood = mood_t'($urandom_range(2));
      pick_request(mood, op, pos, val);
      send_gapped(pct, op, pos, val);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty list, edges of position and value, head/tail/middle,
    // undefined op codes, deletes at both ends and outside the list.
    send_gapped(17, OP_READ,   0,       $urandom);  // read of empty list
    send_gapped(17, OP_READ,   -32768,  $urandom);
    send_gapped(17, OP_DELETE, 0,       $urandom);  // delete of empty list
    send_gapped(17, OP_AT,     1,       $urandom);  // past end of empty list
    send_gapped(17, OP_AT,     32767,   $urandom);
    send_gapped(17, OP_HEAD,   POS_W'($urandom), 32'sh8000_0000);
    send_gapped(17, OP_TAIL,   POS_W'($urandom), 32'sh7fff_ffff);
    send_gapped(17, OP_AT,     -32768,  '0);        // negative index goes to head
    send_gapped(17, OP_AT,     -1,      -1);
    send_gapped(17, OP_AT,     4,       12345);     // index == length: append
    send_gapped(17, OP_AT,     2,       32'sh5a5a_5a5a);
    send_gapped(17, OP_AT,     7,       $urandom);  // index == length + 1: out of range
    send_gapped(17, OP_READ,   0,       $urandom);
    send_gapped(17, OP_READ,   5,       $urandom);  // last entry
    send_gapped(17, OP_READ,   6,       $urandom);  // index == length
    send_gapped(17, OP_READ,   32767,   $urandom);
    send_gapped(17, OP_READ,   -1,      $urandom);
    send_gapped(17, OP_DELETE + 3'd1, POS_W'($urandom), $urandom);
    send_gapped(17, OP_DELETE + 3'd2, POS_W'($urandom), $urandom);
    send_gapped(17, OP_DELETE + 3'd3, -1,       -1);
    send_gapped(17, OP_DELETE, 5,       $urandom);  // tail entry
    send_gapped(17, OP_DELETE, 0,       $urandom);  // head entry
    send_gapped(17, OP_DELETE, -1,      $urandom);
    send_gapped(17, OP_DELETE, 32767,   $urandom);
    send_gapped(17, OP_DELETE, 2,       $urandom);  // middle entry
    drain();

    // Random phases: light sender gaps, heavy gaps, then back to back.
    run_random(610, 17);
    drain();
    run_random(610, 71);
    drain();
    run_random(610, 0);
    drain();

    // give the block time for stray beats after the longest shift
    repeat (150) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
